[sv/hwes_pkg.sv]
package hwes_pkg;

  localparam int SAMPLE_W = 16;
  localparam int ENERGY_W = 52;
  localparam int BAND_W   = 4;
  localparam int COEFF_W  = 10;

  // control from the sequencer to the pair pipeline
  typedef struct packed {
    logic issue;
    logic clear;
  } hwes_pipe_ctl_t;

endpackage

[sv/hwes_if.sv]
interface hwes_sample_if;
  import hwes_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_count;
  logic                series_end;

  modport source (output valid, sample_count, series_end, input ready);
  modport sink   (input valid, sample_count, series_end, output ready);
endinterface

interface hwes_band_if;
  import hwes_pkg::*;

  logic                valid;
  logic                ready;
  logic [BAND_W-1:0]   band_index;
  logic [ENERGY_W-1:0] detail_energy;
  logic [ENERGY_W-1:0] approx_energy;
  logic [COEFF_W-1:0]  coeff_total;
  logic                final_band;

  modport source (output valid, band_index, detail_energy, approx_energy, coeff_total,
                  final_band, input ready);
  modport sink   (input valid, band_index, detail_energy, approx_energy, coeff_total,
                  final_band, output ready);
endinterface

[sv/hwes_store.sv]
module hwes_store #(
  parameter int ADDR_W = 10,
  parameter int DATA_W = 26
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr_a,
  input  logic [ADDR_W-1:0] rd_addr_b,
  output logic [DATA_W-1:0] rd_data_a,
  output logic [DATA_W-1:0] rd_data_b
);

  logic [DATA_W-1:0] mem [1 << ADDR_W];
  logic [DATA_W-1:0] rd_a_r;
  logic [DATA_W-1:0] rd_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_r <= mem[rd_addr_a];
    rd_b_r <= mem[rd_addr_b];
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

[sv/hwes_pair_unit.sv]
module hwes_pair_unit #(
  parameter int ADDR_W = 10,
  parameter int DATA_W = 26
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  hwes_pkg::hwes_pipe_ctl_t ctl,
  input  logic [ADDR_W-1:0]        issue_idx,
  input  logic [DATA_W-1:0]        rd_data_a,
  input  logic [DATA_W-1:0]        rd_data_b,
  output logic                     wr_en,
  output logic [ADDR_W-1:0]        wr_addr,
  output logic [DATA_W-1:0]        wr_data,
  output logic                     busy,
  output logic [hwes_pkg::ENERGY_W-1:0] detail_energy,
  output logic [hwes_pkg::ENERGY_W-1:0] approx_energy
);
  import hwes_pkg::*;

  logic                v1_r, v2_r, v3_r;
  logic [ADDR_W-1:0]   j1_r, j2_r;
  logic [DATA_W-1:0]   sum_r, dmag_r;
  logic [ENERGY_W-1:0] sq_d_r, sq_s_r;
  logic [ENERGY_W-1:0] acc_d_r, acc_s_r;
  logic [2*DATA_W-1:0] prod_d, prod_s;

  assign prod_d = dmag_r * dmag_r;
  assign prod_s = sum_r * sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      acc_d_r <= '0;
      acc_s_r <= '0;
    end else begin
      v1_r <= ctl.issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (ctl.clear) begin
        acc_d_r <= '0;
        acc_s_r <= '0;
      end else if (v3_r) begin
        // modulo 2^52 wrap is the intended masking
        acc_d_r <= acc_d_r + sq_d_r;
        acc_s_r <= acc_s_r + sq_s_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    j1_r   <= issue_idx;
    j2_r   <= j1_r;
    sum_r  <= rd_data_a + rd_data_b;
    dmag_r <= (rd_data_a >= rd_data_b) ? (rd_data_a - rd_data_b) : (rd_data_b - rd_data_a);
    sq_d_r <= ENERGY_W'(prod_d);
    sq_s_r <= ENERGY_W'(prod_s);
  end

  // pair sum goes back to the low half of the store, behind the read front
  assign wr_en         = v2_r;
  assign wr_addr       = j2_r;
  assign wr_data       = sum_r;
  assign busy          = v1_r | v2_r | v3_r;
  assign detail_energy = acc_d_r;
  assign approx_energy = acc_s_r;

endmodule

[sv/haar_wavelet_energy_spectrum.sv]
// Haar energy spectrum of a packet-count series. Samples stream in at one per
// cycle and are written into a 2^MAX_LOG2_SAMPLES entry store; samples past the
// store depth are dropped. A request with series_end set closes the series: the
// first 2^L samples (L = floor(log2 n), n loaded) are transformed in place with
// unnormalized pair sums and differences, and one result per band comes out,
// finest first, carrying exact sums of squared detail and approximation
// coefficients, the pair count and a flag on the coarsest band. Series shorter
// than two samples give no result. During the transform no sample is accepted:
// band b holds 2^(L-1-b) pairs, read at one pair per cycle through the store's
// two read ports, followed by pipeline drain and result hand-off, which waits
// while the result channel stalls. The energies need no software-side overflow
// care at the default depth; scaling by 2^(band+1) is left to software.
module haar_wavelet_energy_spectrum #(
  parameter int MAX_LOG2_SAMPLES = 10
) (
  input  logic       clk,
  input  logic       rst_n,
  hwes_sample_if.sink  in_ch,
  hwes_band_if.source  out_ch
);
  import hwes_pkg::*;

  localparam int ADDR_W = MAX_LOG2_SAMPLES;
  localparam int DATA_W = SAMPLE_W + MAX_LOG2_SAMPLES;
  localparam int LG_W   = $clog2(MAX_LOG2_SAMPLES + 1);

  typedef enum logic [1:0] {S_LOAD, S_READ, S_DRAIN, S_EMIT} state_t;

  state_t              state_r;
  logic [ADDR_W:0]     cnt_r;
  logic [LG_W-1:0]     lg_r;
  logic [BAND_W-1:0]   band_r;
  logic [ADDR_W-1:0]   pairs_r;
  logic [ADDR_W-1:0]   j_r;
  logic                out_valid_r;
  logic [BAND_W-1:0]   out_band_r;
  logic [ENERGY_W-1:0] out_detail_r;
  logic [ENERGY_W-1:0] out_approx_r;
  logic [COEFF_W-1:0]  out_coeff_r;
  logic                out_final_r;

  logic                in_fire, load_we, out_load, last_band;
  logic [ADDR_W:0]     n_c;
  logic [LG_W-1:0]     lg_c;
  hwes_pipe_ctl_t      pipe_ctl;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_wa, rd_addr_a, rd_addr_b;
  logic [DATA_W-1:0]   mem_wd, rd_data_a, rd_data_b;
  logic                pu_wr_en, pu_busy;
  logic [ADDR_W-1:0]   pu_wr_addr;
  logic [DATA_W-1:0]   pu_wr_data;
  logic [ENERGY_W-1:0] pu_detail, pu_approx;

  assign in_ch.ready = (state_r == S_LOAD);
  assign in_fire     = in_ch.valid && in_ch.ready;
  // count msb set means the store is full
  assign load_we     = in_fire && !cnt_r[ADDR_W];
  assign n_c         = cnt_r[ADDR_W] ? cnt_r : cnt_r + 1'b1;

  always_comb begin
    lg_c = '0;
    for (int i = 1; i <= ADDR_W; i++) begin
      if (n_c[i]) lg_c = LG_W'(i);
    end
  end

  assign last_band = (LG_W'(band_r) == lg_r - LG_W'(1));
  assign out_load  = (state_r == S_EMIT) && (!out_valid_r || out_ch.ready);

  assign pipe_ctl.issue = (state_r == S_READ);
  assign pipe_ctl.clear = out_load;

  assign rd_addr_a = j_r << 1;
  assign rd_addr_b = rd_addr_a | ADDR_W'(1);

  assign mem_we = load_we | pu_wr_en;
  assign mem_wa = (state_r == S_LOAD) ? cnt_r[ADDR_W-1:0] : pu_wr_addr;
  assign mem_wd = (state_r == S_LOAD) ? DATA_W'(in_ch.sample_count) : pu_wr_data;

  hwes_store #(.ADDR_W(ADDR_W), .DATA_W(DATA_W)) u_store (
    .clk       (clk),
    .wr_en     (mem_we),
    .wr_addr   (mem_wa),
    .wr_data   (mem_wd),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  hwes_pair_unit #(.ADDR_W(ADDR_W), .DATA_W(DATA_W)) u_pair (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (pipe_ctl),
    .issue_idx     (j_r),
    .rd_data_a     (rd_data_a),
    .rd_data_b     (rd_data_b),
    .wr_en         (pu_wr_en),
    .wr_addr       (pu_wr_addr),
    .wr_data       (pu_wr_data),
    .busy          (pu_busy),
    .detail_energy (pu_detail),
    .approx_energy (pu_approx)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      lg_r        <= '0;
      band_r      <= '0;
      pairs_r     <= '0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ch.ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_LOAD: begin
          if (in_fire) begin
            if (in_ch.series_end) begin
              cnt_r <= '0;
              if (lg_c != '0) begin
                lg_r    <= lg_c;
                band_r  <= '0;
                pairs_r <= ADDR_W'(1) << (lg_c - LG_W'(1));
                j_r     <= '0;
                state_r <= S_READ;
              end
            end else if (!cnt_r[ADDR_W]) begin
              cnt_r <= cnt_r + 1'b1;
            end
          end
        end
        S_READ: begin
          if (j_r == pairs_r - ADDR_W'(1)) begin
            state_r <= S_DRAIN;
          end else begin
            j_r <= j_r + 1'b1;
          end
        end
        S_DRAIN: begin
          if (!pu_busy) begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_load) begin
            out_valid_r  <= 1'b1;
            out_band_r   <= band_r;
            out_detail_r <= pu_detail;
            out_approx_r <= pu_approx;
            out_coeff_r  <= COEFF_W'(pairs_r);
            out_final_r  <= last_band;
            if (last_band) begin
              state_r <= S_LOAD;
            end else begin
              band_r  <= band_r + 1'b1;
              pairs_r <= pairs_r >> 1;
              j_r     <= '0;
              state_r <= S_READ;
            end
          end
        end
        default: begin
          state_r <= S_LOAD;
        end
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.band_index    = out_band_r;
  assign out_ch.detail_energy = out_detail_r;
  assign out_ch.approx_energy = out_approx_r;
  assign out_ch.coeff_total   = out_coeff_r;
  assign out_ch.final_band    = out_final_r;

`ifndef SYNTHESIS
  // loading must never overlap writeback into the store
  a_no_load_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !pu_busy)
    else $error("sample accepted while pair pipeline busy");

  a_pair_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> (j_r < pairs_r))
    else $error("pair index past band length");

  a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (ADDR_W + 1)'(1 << ADDR_W))
    else $error("sample count beyond store depth");

  a_final_single_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.final_band) |-> (out_ch.coeff_total == COEFF_W'(1)))
    else $error("coarsest band does not hold one pair");

  a_emit_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> !pu_busy)
    else $error("result taken before accumulation finished");
`endif

endmodule
